/* sv/sbs_pkg.sv */
// Shared types, constants and the cell character function of the spectrum bar smoother.
// Depends on nothing; every other file of the block but sbs_hist_mem uses it.
`timescale 1ns / 1ps

package sbs_pkg;

	// Widths and counts that do not vary with the module parameters
	localparam int SUM_W      = 12; // holds up to 16 levels of 255
	localparam int SUM_LANES  = 4;  // history levels added per accumulate cycle
	localparam int DIV_STEPS  = 4;  // divider steps, two quotient bits each
	localparam int CELL_STEPS = 8;

	localparam logic [7:0] SPACE_CODE = 8'd32;

	// Configuration register indexes
	localparam logic [1:0] CFG_DEPTH = 2'd0;
	localparam logic [1:0] CFG_LINES = 2'd1;
	localparam logic [1:0] CFG_BLACK = 2'd2;
	localparam logic [1:0] CFG_MARK  = 2'd3;

	typedef logic [7:0] level_t;

	typedef struct packed {
		logic [3:0] depth;
		logic [2:0] lines;
		logic [7:0] black;
		logic       mark;
	} cfg_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clear_wr;
		logic take_in;
		logic shift;
		logic sum_step;
		logic div_step;
		logic div_first;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clear_last;
		logic sum_last;
	} stat_t;

	// Character codes for a cell fill of 0 to 8 eighths
	localparam logic [7:0] CELL_CODES [0:8] = '{
		8'd0, 8'd176, 8'd158, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135, 8'd136
	};

	// Character for one display line; line_idx 0 is the bottom line, lines is 1..4
	function automatic logic [7:0] cell_char(
		input logic [7:0] avg,
		input logic [1:0] line_idx,
		input logic [2:0] lines,
		input logic [7:0] black,
		input logic       mark
	);
		logic [7:0] base;
		logic [7:0] diff;
		logic [3:0] fill;
		logic [7:0] code;
		base = {3'b000, line_idx, 3'b000};
		diff = (avg > base) ? (avg - base) : 8'd0;
		fill = (diff > 8'(CELL_STEPS)) ? 4'(CELL_STEPS) : diff[3:0];
		if (fill == 4'd0 && line_idx == 2'd0 && mark) begin
			fill = 4'd1;
		end
		if ({1'b0, line_idx} >= lines) begin
			code = SPACE_CODE;
		end else if (fill == 4'd0) begin
			code = SPACE_CODE;
		end else if (fill == 4'(CELL_STEPS) && black != 8'd0) begin
			code = black;
		end else begin
			code = CELL_CODES[fill];
		end
		return code;
	endfunction

endpackage

/* sv/spectrum_bar_smoother.sv */
// Top level of the spectrum bar smoother: configuration registers, controller and
// datapath. Uses sbs_pkg, sbs_ctrl and sbs_datapath.
//
//  channel  direction  handshake             payload
//  input    in         in_valid / in_ready   bin_level, last_bin
//  result   out        out_valid / out_ready bin_number, smoothed_level, line1..4_char,
//                                            frame_end
//  config   in         cfg_wr_en             cfg_index, cfg_data
//
// A word passes through accept and history read, shift and write-back, four levels per
// accumulate cycle, four divider steps and result load; the iterative divider and the
// four-lane accumulator set how long that takes.
// After reset a clearing pass zeroes every bin row of the history, one row a cycle;
// in_ready stays low meanwhile. A stalled result waits in the output register while
// the next word is accepted and worked on.
`timescale 1ns / 1ps

module spectrum_bar_smoother #(
	parameter int BIN_COUNT     = 256,
	parameter int HISTORY_DEPTH = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] bin_level,
	input  logic       last_bin,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] bin_number,
	output logic [7:0] smoothed_level,
	output logic [7:0] line1_char,
	output logic [7:0] line2_char,
	output logic [7:0] line3_char,
	output logic [7:0] line4_char,
	output logic       frame_end
);
	import sbs_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth <= 4'd1;
			cfg_q.lines <= 3'd1;
			cfg_q.black <= 8'd0;
			cfg_q.mark  <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_DEPTH: cfg_q.depth <= cfg_data[3:0];
				CFG_LINES: cfg_q.lines <= cfg_data[2:0];
				CFG_BLACK: cfg_q.black <= cfg_data;
				CFG_MARK:  cfg_q.mark  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	sbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sbs_datapath #(
		.BIN_COUNT     (BIN_COUNT),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.stat           (stat),
		.bin_level      (bin_level),
		.last_bin       (last_bin),
		.bin_number     (bin_number),
		.smoothed_level (smoothed_level),
		.line1_char     (line1_char),
		.line2_char     (line2_char),
		.line3_char     (line3_char),
		.line4_char     (line4_char),
		.frame_end      (frame_end)
	);

endmodule

/* sv/sbs_hist_mem.sv */
// Level history memory of the spectrum bar smoother: one row of levels per bin.
// One write port, one read port with registered read data. Depends on nothing.
`timescale 1ns / 1ps

module sbs_hist_mem #(
	parameter int DEPTH  = 256,
	parameter int WIDTH  = 80,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one row
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read one row into the output register
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* sv/sbs_div.sv */
// Iterative divider of the spectrum bar smoother: level sum over depth, two quotient
// bits a cycle. Uses sbs_pkg for the sum width.
`timescale 1ns / 1ps

module sbs_div (
	input  logic                     clk,
	input  logic                     step,
	input  logic                     first,
	input  logic [sbs_pkg::SUM_W-1:0] dividend,
	input  logic [3:0]               divisor,
	output logic [7:0]               quotient
);
	import sbs_pkg::*;

	localparam int BITS_PER_STEP = 2;

	// The sum is below 256 times the divisor, so its top bits start the remainder
	logic [3:0] rem_q;
	logic [7:0] bits_q;
	logic [7:0] quo_q;

	logic [3:0] rem_d;
	logic [7:0] bits_d;
	logic [7:0] quo_d;

	// Two restoring steps
	always_comb begin
		logic [4:0] trial;
		rem_d  = first ? dividend[SUM_W-1:8] : rem_q;
		bits_d = first ? dividend[7:0] : bits_q;
		quo_d  = first ? 8'd0 : quo_q;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			trial  = {rem_d, bits_d[7]};
			bits_d = {bits_d[6:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_d = 4'(trial - {1'b0, divisor});
				quo_d = {quo_d[6:0], 1'b1};
			end else begin
				rem_d = trial[3:0];
				quo_d = {quo_d[6:0], 1'b0};
			end
		end
	end

	// Advance one step
	always_ff @(posedge clk) begin
		if (step) begin
			rem_q  <= rem_d;
			bits_q <= bits_d;
			quo_q  <= quo_d;
		end
	end

	assign quotient = quo_q;

endmodule

/* sv/sbs_ctrl.sv */
// Controller of the spectrum bar smoother: clearing pass, word sequencing and the
// result handshake. Uses sbs_pkg for the command and status structs.
`timescale 1ns / 1ps

module sbs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  sbs_pkg::stat_t stat,
	output sbs_pkg::cmd_t  cmd
);
	import sbs_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_SUM   = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	localparam int DCNT_W = $clog2(DIV_STEPS);

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [DCNT_W-1:0] div_cnt_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d     = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				state_d   = S_SUM;
			end
			S_SUM: begin
				cmd.sum_step = 1'b1;
				if (stat.sum_last) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (div_cnt_q == '0);
				if (div_cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state and the divider step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	// Result valid: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* sv/sbs_datapath.sv */
// Datapath of the spectrum bar smoother: bin pointer, history shift, level sum,
// divider and character mapping. Uses sbs_pkg, sbs_hist_mem and sbs_div.
`timescale 1ns / 1ps

module sbs_datapath #(
	parameter int BIN_COUNT     = 256,
	parameter int HISTORY_DEPTH = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sbs_pkg::cfg_t  cfg,
	input  sbs_pkg::cmd_t  cmd,
	output sbs_pkg::stat_t stat,
	input  logic [7:0]     bin_level,
	input  logic           last_bin,
	output logic [7:0]     bin_number,
	output logic [7:0]     smoothed_level,
	output logic [7:0]     line1_char,
	output logic [7:0]     line2_char,
	output logic [7:0]     line3_char,
	output logic [7:0]     line4_char,
	output logic           frame_end
);
	import sbs_pkg::*;

	localparam int PTR_W = $clog2(BIN_COUNT);
	localparam int ROW_W = 8 * HISTORY_DEPTH;
	localparam int ROW_N = HISTORY_DEPTH + SUM_LANES;

	logic [PTR_W-1:0] bin_ptr_q;
	logic [PTR_W-1:0] clear_ptr_q;
	logic [PTR_W-1:0] bin_q;
	level_t           level_q;
	logic             last_q;

	logic [ROW_W-1:0] rd_row;
	logic [ROW_W-1:0] new_row_flat;
	logic [ROW_W-1:0] wr_row;
	logic [PTR_W-1:0] wr_addr;
	level_t           old_row [HISTORY_DEPTH];
	level_t           new_row [HISTORY_DEPTH];

	logic [3:0]       depth_eff;
	logic [3:0]       shift_top;
	logic [2:0]       lines_eff;

	level_t           acc_q [ROW_N];
	logic [3:0]       cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] lane_sum;
	logic [7:0]       quotient;

	// Clamp the depth and line count into range
	always_comb begin
		if (cfg.depth == 4'd0) begin
			depth_eff = 4'd1;
		end else if (cfg.depth > HISTORY_DEPTH) begin
			depth_eff = 4'(HISTORY_DEPTH);
		end else begin
			depth_eff = cfg.depth;
		end
		shift_top = (depth_eff > HISTORY_DEPTH - 1) ? 4'(HISTORY_DEPTH - 1) : depth_eff;
		if (cfg.lines == 3'd0) begin
			lines_eff = 3'd1;
		end else if (cfg.lines > 3'd4) begin
			lines_eff = 3'd4;
		end else begin
			lines_eff = cfg.lines;
		end
	end

	// Advance the bin pointer and the clearing pointer; latch the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_ptr_q   <= '0;
			clear_ptr_q <= '0;
		end else begin
			if (cmd.take_in) begin
				if (last_bin || bin_ptr_q == PTR_W'(BIN_COUNT - 1)) begin
					bin_ptr_q <= '0;
				end else begin
					bin_ptr_q <= bin_ptr_q + 1'b1;
				end
			end
			if (cmd.clear_wr) begin
				clear_ptr_q <= clear_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			bin_q   <= bin_ptr_q;
			level_q <= bin_level;
			last_q  <= last_bin;
		end
	end

	assign stat.clear_last = (clear_ptr_q == PTR_W'(BIN_COUNT - 1));

	// Shift the history row of the bin up to the capped top entry, new level at the bottom
	always_comb begin
		for (int j = 0; j < HISTORY_DEPTH; j++) begin
			old_row[j] = rd_row[8*j +: 8];
		end
		new_row[0] = level_q;
		for (int j = 1; j < HISTORY_DEPTH; j++) begin
			new_row[j] = (j <= shift_top) ? old_row[j-1] : old_row[j];
		end
		for (int j = 0; j < HISTORY_DEPTH; j++) begin
			new_row_flat[8*j +: 8] = new_row[j];
		end
	end

	assign wr_row  = cmd.clear_wr ? '0 : new_row_flat;
	assign wr_addr = cmd.clear_wr ? clear_ptr_q : bin_q;

	sbs_hist_mem #(
		.DEPTH  (BIN_COUNT),
		.WIDTH  (ROW_W),
		.ADDR_W (PTR_W)
	) u_hist_mem (
		.clk     (clk),
		.wr_en   (cmd.clear_wr || cmd.shift),
		.wr_addr (wr_addr),
		.wr_data (wr_row),
		.rd_en   (cmd.take_in),
		.rd_addr (bin_ptr_q),
		.rd_data (rd_row)
	);

	// Add up to four levels of the lowest lanes that are still inside the depth
	always_comb begin
		lane_sum = '0;
		for (int k = 0; k < SUM_LANES; k++) begin
			if (k < cnt_q) begin
				lane_sum = lane_sum + SUM_W'(acc_q[k]);
			end
		end
	end

	assign stat.sum_last = (cnt_q <= 4'(SUM_LANES));

	// Load the shifted row, then accumulate four lanes a cycle
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			for (int j = 0; j < HISTORY_DEPTH; j++) begin
				acc_q[j] <= new_row[j];
			end
			for (int j = HISTORY_DEPTH; j < ROW_N; j++) begin
				acc_q[j] <= 8'd0;
			end
			cnt_q <= depth_eff;
			sum_q <= '0;
		end else if (cmd.sum_step) begin
			for (int j = 0; j < HISTORY_DEPTH; j++) begin
				acc_q[j] <= acc_q[j+SUM_LANES];
			end
			for (int j = HISTORY_DEPTH; j < ROW_N; j++) begin
				acc_q[j] <= 8'd0;
			end
			cnt_q <= (cnt_q > 4'(SUM_LANES)) ? cnt_q - 4'(SUM_LANES) : 4'd0;
			sum_q <= sum_q + lane_sum;
		end
	end

	sbs_div u_div (
		.clk      (clk),
		.step     (cmd.div_step),
		.first    (cmd.div_first),
		.dividend (sum_q),
		.divisor  (depth_eff),
		.quotient (quotient)
	);

	// Output register: hold the result word until the next load
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			bin_number     <= 8'(bin_q);
			smoothed_level <= quotient;
			line1_char     <= cell_char(quotient, 2'd0, lines_eff, cfg.black, cfg.mark);
			line2_char     <= cell_char(quotient, 2'd1, lines_eff, cfg.black, cfg.mark);
			line3_char     <= cell_char(quotient, 2'd2, lines_eff, cfg.black, cfg.mark);
			line4_char     <= cell_char(quotient, 2'd3, lines_eff, cfg.black, cfg.mark);
			frame_end      <= last_q;
		end
	end

endmodule

/* sv/sbs_checker.sv */
// Port-level checks of the spectrum bar smoother, bound to the top level.
// Uses sbs_pkg for the space code.
`timescale 1ns / 1ps

module sbs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] bin_number,
	input logic [7:0] smoothed_level,
	input logic [7:0] line2_char,
	input logic [7:0] line3_char,
	input logic [7:0] line4_char
);
	import sbs_pkg::*;

	// An accepted word keeps the input side closed through its shift and first sum step
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input accepted again too soon after a word");

	// A stalled result word holds its level and bin number
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(smoothed_level)
			&& $stable(bin_number))
		else $error("stalled result word changed");

	// A level below one full cell leaves the upper lines blank
	a_upper_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && smoothed_level < 8'd8 |-> line2_char == SPACE_CODE
			&& line3_char == SPACE_CODE && line4_char == SPACE_CODE)
		else $error("upper line not blank for a low level");

endmodule

bind spectrum_bar_smoother sbs_checker u_sbs_checker (.*);

/* test/tb_top.sv */
// Self-checking testbench for spectrum_bar_smoother: a per-bin moving-average predictor
// and bar-character scoreboard, with randomised handshakes on both channels.
// Depends on sbs_pkg and the spectrum_bar_smoother RTL.
`timescale 1ns / 1ps

// One result word as it leaves the block
typedef struct packed {
	logic [7:0] bin;
	logic [7:0] avg;
	logic [7:0] l1;
	logic [7:0] l2;
	logic [7:0] l3;
	logic [7:0] l4;
	logic       fe;
} bar_word_t;

// Mirror of the smoother state plus the queue of words still owed by the block
class bar_book;
	localparam int BINS  = 256;
	localparam int SLOTS = 10;

	logic [7:0]  hist [BINS][SLOTS];
	int unsigned ptr;
	logic [3:0]  depth_r;
	logic [2:0]  lines_r;
	logic [7:0]  black_r;
	logic        mark_r;
	bar_word_t   due_q [$];
	int          errors;
	int          seen;

	function new();
		for (int b = 0; b < BINS; b++) begin
			for (int s = 0; s < SLOTS; s++) begin
				hist[b][s] = 8'd0;
			end
		end
		ptr = 0;
		depth_r = 4'd1;
		lines_r = 3'd1;
		black_r = 8'd0;
		mark_r = 1'b0;
		errors = 0;
		seen = 0;
	endfunction

	function int pending();
		return due_q.size();
	endfunction

	function void set_reg(logic [1:0] idx, logic [7:0] data);
		case (idx)
			sbs_pkg::CFG_DEPTH: depth_r = data[3:0];
			sbs_pkg::CFG_LINES: lines_r = data[2:0];
			sbs_pkg::CFG_BLACK: black_r = data;
			sbs_pkg::CFG_MARK:  mark_r = data[0];
			default: ;
		endcase
	endfunction

	// Bar glyph for a partial fill of 0 to 8 eighths
	function logic [7:0] glyph(int unsigned fill);
		case (fill)
			1: return 8'd176;
			2: return 8'd158;
			3: return 8'd131;
			4: return 8'd132;
			5: return 8'd133;
			6: return 8'd134;
			7: return 8'd135;
			8: return 8'd136;
			default: return 8'd0;
		endcase
	endfunction

	// Character for display line 1 (bottom) to 4 (top)
	function logic [7:0] line_code(int unsigned avg, int unsigned line, int unsigned nl);
		int unsigned base;
		int unsigned fill;
		if (line > nl) begin
			return sbs_pkg::SPACE_CODE;
		end
		base = (line - 1) * 8;
		fill = (avg > base) ? avg - base : 0;
		if (fill > 8) begin
			fill = 8;
		end
		// lift an empty bottom cell to the lowest bar when marking is on
		if (fill == 0 && line == 1 && mark_r) begin
			fill = 1;
		end
		if (fill == 0) begin
			return sbs_pkg::SPACE_CODE;
		end
		if (fill == 8 && black_r != 8'd0) begin
			return black_r;
		end
		return glyph(fill);
	endfunction

	// Shift the bin history, average and queue the word the block owes
	function void note_bin(logic [7:0] level, logic last);
		int unsigned d;
		int unsigned nl;
		int unsigned top;
		int unsigned sum;
		int unsigned avg;
		int j;
		bar_word_t w;
		d = depth_r;
		if (d == 0) d = 1;
		if (d > SLOTS) d = SLOTS;
		nl = lines_r;
		if (nl == 0) nl = 1;
		if (nl > 4) nl = 4;
		// only slots 1..depth move; deeper slots keep stale levels
		top = (d > SLOTS - 1) ? SLOTS - 1 : d;
		for (j = top; j > 0; j--) begin
			hist[ptr][j] = hist[ptr][j - 1];
		end
		hist[ptr][0] = level;
		sum = 0;
		for (j = 0; j < d; j++) begin
			sum += hist[ptr][j];
		end
		avg = sum / d;
		w.bin = ptr[7:0];
		w.avg = avg[7:0];
		w.l1 = line_code(avg, 1, nl);
		w.l2 = line_code(avg, 2, nl);
		w.l3 = line_code(avg, 3, nl);
		w.l4 = line_code(avg, 4, nl);
		w.fe = last;
		due_q.push_back(w);
		// advance the bin pointer, wrapping on frame end or the last bin
		if (last || ptr + 1 >= BINS) begin
			ptr = 0;
		end else begin
			ptr = ptr + 1;
		end
	endfunction

	task report(string msg);
		$display("MISMATCH at word %0d: %s", seen, msg);
		errors++;
	endtask

	task match(string field, logic [7:0] got, logic [7:0] want);
		if (got !== want) begin
			report($sformatf("%s got %0d, expected %0d", field, got, want));
		end
	endtask

	task check_word(bar_word_t got);
		bar_word_t want;
		seen++;
		if (due_q.size() == 0) begin
			report($sformatf("word for bin %0d with none outstanding", got.bin));
			return;
		end
		want = due_q.pop_front();
		match("bin_number", got.bin, want.bin);
		match("smoothed_level", got.avg, want.avg);
		match("line1_char", got.l1, want.l1);
		match("line2_char", got.l2, want.l2);
		match("line3_char", got.l3, want.l3);
		match("line4_char", got.l4, want.l4);
		match("frame_end", {7'd0, got.fe}, {7'd0, want.fe});
	endtask

	task finish_check();
		if (due_q.size() != 0) begin
			report($sformatf("%0d words never arrived", due_q.size()));
		end
	endtask
endclass

module tb_top;

	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AT      = 150;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] bin_level;
	logic       last_bin;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] bin_number;
	logic [7:0] smoothed_level;
	logic [7:0] line1_char;
	logic [7:0] line2_char;
	logic [7:0] line3_char;
	logic [7:0] line4_char;
	logic       frame_end;

	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	bar_book book = new();

	spectrum_bar_smoother dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.bin_level     (bin_level),
		.last_bin      (last_bin),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.bin_number    (bin_number),
		.smoothed_level(smoothed_level),
		.line1_char    (line1_char),
		.line2_char    (line2_char),
		.line3_char    (line3_char),
		.line4_char    (line4_char),
		.frame_end     (frame_end)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog
	initial begin : watchdog
		#1_000_000;
		$display("Verification failed");
		$finish;
	end

	// Write one register at the next falling edge; the caller drops the enable
	task automatic write_reg(logic [1:0] idx, logic [7:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		book.set_reg(idx, data);
	endtask

	// Load all four registers; noisy fills the unused upper bits with junk
	task automatic load_setting(logic [3:0] depth, logic [2:0] lines, logic [7:0] black,
		logic mark, bit noisy);
		logic [7:0] junk;
		junk = noisy ? 8'($urandom) : 8'd0;
		write_reg(sbs_pkg::CFG_DEPTH, {junk[7:4], depth});
		write_reg(sbs_pkg::CFG_LINES, {junk[7:3], lines});
		write_reg(sbs_pkg::CFG_BLACK, black);
		write_reg(sbs_pkg::CFG_MARK, {junk[7:1], mark});
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Offer one bin word and hold it until taken
	task automatic send_bin(logic [7:0] lvl, logic lst);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		bin_level <= lvl;
		last_bin <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		book.note_bin(lvl, lst);
	endtask

	// Drop valid, wait for every owed word, then let the pipeline go quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Levels mostly within the four-line bar range, with extremes mixed in
	function automatic logic [7:0] rand_level();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return 8'($urandom_range(0, 40));
		if (r < 7) return 8'($urandom_range(0, 255));
		if (r == 7) return 8'd0;
		if (r == 8) return 8'd255;
		return 8'($urandom_range(0, 8));
	endfunction

	// Accept result words, with random stalls and one long hold-off to back up the input
	initial begin : result_sink
		int stall;
		bit held;
		bar_word_t got;
		out_ready = 1'b0;
		held = 1'b0;
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 5);
			@(negedge clk);
			if (!held && book.seen >= HOLD_AT) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got = '{bin_number, smoothed_level, line1_char, line2_char, line3_char,
				line4_char, frame_end};
			book.check_word(got);
		end
	end

	initial begin : stimulus
		logic [7:0] edge_levels [12];
		logic [3:0] dep [7];
		logic [2:0] lin [7];
		logic [7:0] blk [7];
		logic       mrk [7];
		int p;
		int k;
		int n;
		int flen;
		in_valid = 1'b0;
		bin_level = 8'd0;
		last_bin = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = sbs_pkg::CFG_DEPTH;
		cfg_data = 8'd0;
		arst_n = 1'b0;
		edge_levels = '{8'd0, 8'd1, 8'd7, 8'd8, 8'd9, 8'd16, 8'd24, 8'd31, 8'd32, 8'd33,
			8'd128, 8'd255};
		dep = '{4'd10, 4'd4, 4'd0, 4'd15, 4'd1, 4'd7, 4'd10};
		lin = '{3'd4, 3'd2, 3'd0, 3'd7, 3'd4, 3'd3, 3'd5};
		blk = '{8'd0, 8'd255, 8'd0, 8'd1, 8'd0, 8'd0, 8'd255};
		mrk = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
		blk[4] = 8'($urandom_range(2, 254));

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Cell boundaries on all four lines, empty bottom cell marked
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		load_setting(4'd1, 3'd4, 8'd0, 1'b1, 1'b0);
		for (k = 0; k < 12; k++) begin
			send_bin(edge_levels[k], k == 11);
		end
		settle();

		// Depth and line count above range, black code on full cells, one-bin frames
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		load_setting(4'd15, 3'd7, 8'd255, 1'b0, 1'b0);
		for (k = 0; k < 8; k++) begin
			send_bin((k < 4) ? 8'd255 : 8'd0, 1'b1);
		end
		settle();

		// Depth and line count of zero
		load_setting(4'd0, 3'd0, 8'd1, 1'b1, 1'b0);
		send_bin(8'd0, 1'b0);
		send_bin(8'd9, 1'b0);
		send_bin(8'd8, 1'b0);
		send_bin(8'd255, 1'b1);
		settle();

		// Random phases; the first runs past the last bin without frame ends to force a wrap
		for (p = 0; p < 7; p++) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			load_setting(dep[p], lin[p], blk[p], mrk[p], 1'b1);
			if (p == 0) begin
				for (k = 0; k < 260; k++) begin
					send_bin(rand_level(), 1'b0);
				end
			end else begin
				n = 0;
				while (n < 90) begin
					flen = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6)
						: $urandom_range(7, 40);
					for (k = 0; k < flen; k++) begin
						send_bin(rand_level(), k == flen - 1);
					end
					n += flen;
				end
			end
			settle();
		end

		book.finish_check();
		if (book.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/sbs_pkg.sv
sv/sbs_hist_mem.sv
sv/sbs_div.sv
sv/sbs_ctrl.sv
sv/sbs_datapath.sv
sv/spectrum_bar_smoother.sv
sv/sbs_checker.sv
test/tb_top.sv
